// ----- sv/lock_contention_monitor_table_assert.svh -----
// Assertion macros for the lock contention monitor table.
// Used by the controller; clock and reset are the module's own ports.
`ifndef LOCK_CONTENTION_MONITOR_TABLE_ASSERT_SVH
`define LOCK_CONTENTION_MONITOR_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define LCMT_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define LCMT_NEVER(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition");
`else
`define LCMT_ASSERT(name, prop)
`define LCMT_NEVER(name, expr)
`endif
`endif

// ----- sv/lcmt_pkg.sv -----
// Shared types and constants of the lock contention monitor table.
// No dependencies.
package lcmt_pkg;

   // BUCKETS and WAYS are powers of two: bucket and way concatenate to a slot
   localparam int BUCKETS    = 1024;
   localparam int WAYS       = 32;
   localparam int HASH_SHIFT = 5;
   localparam int SLOT_TOTAL = BUCKETS * WAYS;
   localparam int BUCKET_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SLOT_W     = $clog2(SLOT_TOTAL) > 0 ? $clog2(SLOT_TOTAL) : 1;
   localparam int INDEX_W    = 15;

   typedef enum logic [1:0] {
      ACT_LOCK   = 2'd0,
      ACT_TRY    = 2'd1,
      ACT_UNLOCK = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_CLR_RSP,
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [31:0] owner;
      logic [31:0] caller;
      logic [31:0] success;
      logic [31:0] fail;
      logic [31:0] masked;
      logic [31:0] depth;
      logic [31:0] mark;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic search;
      logic clear_start;
      logic clear_step;
      logic update;
      logic rsp_zero;
   } dp_cmd_type;

   typedef struct packed {
      logic req_clear;
      logic req_zero;
      logic found;
      logic full;
      logic clear_last;
      logic rsp_busy;
   } dp_status_type;

endpackage

// ----- sv/lcmt_datapath.sv -----
// Datapath: event registers, slot memory, overflow entry, update and result registers.
// Depends on lcmt_pkg.
module lcmt_datapath import lcmt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [1:0]    req_action,
   input  logic [31:0]   req_lock_address,
   input  logic [31:0]   req_caller_address,
   input  logic          req_acquired_at_once,
   input  logic          req_interrupts_masked,
   input  logic          req_thread_present,
   input  logic [31:0]   req_thread_lock_depth,
   input  logic [31:0]   req_time_ms,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_overflowed,
   output logic [14:0]   rsp_slot_index,
   output logic [31:0]   rsp_success_count,
   output logic [31:0]   rsp_fail_count,
   output logic [31:0]   rsp_masked_count,
   output logic [31:0]   rsp_depth_record,
   output logic [31:0]   rsp_time_mark,
   output logic [31:0]   rsp_caller_record
);

   entry_type            mem [SLOT_TOTAL];
   entry_type            rd_data_ff;
   entry_type            entry_ff;
   entry_type            base_entry;
   entry_type            new_entry;
   logic [1:0]           action_ff;
   logic [31:0]          addr_ff;
   logic [31:0]          caller_ff;
   logic                 acquired_ff;
   logic                 masked_ff;
   logic                 thread_ff;
   logic [31:0]          depth_ff;
   logic [31:0]          now_ff;
   logic [WAY_W-1:0]     way_ff;
   logic [WAY_W-1:0]     chk_way_ff;
   logic                 chk_valid_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic                 over_ff;
   logic [SLOT_W-1:0]    clr_addr_ff;
   logic [31:0]          ovf_success_ff, ovf_fail_ff, ovf_masked_ff, ovf_depth_ff, ovf_mark_ff;
   logic [BUCKET_W-1:0]  bucket;
   logic [SLOT_W-1:0]    rd_addr;
   logic                 mem_we;
   logic [SLOT_W-1:0]    wr_addr;
   entry_type            wr_data;
   logic                 hit;
   logic                 rsp_valid_ff;
   logic                 rsp_over_ff;
   logic [14:0]          rsp_index_ff;
   entry_type            rsp_entry_ff;

   assign bucket  = addr_ff[HASH_SHIFT +: BUCKET_W];
   assign rd_addr = {bucket, way_ff};
   assign hit     = chk_valid_ff &&
                    (rd_data_ff.owner == addr_ff || rd_data_ff.owner == 32'd0);

   assign status.req_clear  = (req_action == ACT_CLEAR);
   assign status.req_zero   = (req_lock_address == 32'd0);
   assign status.found      = hit;
   assign status.full       = chk_valid_ff && !hit && (chk_way_ff == WAY_W'(WAYS - 1));
   assign status.clear_last = (clr_addr_ff == SLOT_W'(SLOT_TOTAL - 1));
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   // event registers and search bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff   <= req_action;
         addr_ff     <= req_lock_address;
         caller_ff   <= req_caller_address;
         acquired_ff <= req_acquired_at_once;
         masked_ff   <= req_interrupts_masked;
         thread_ff   <= req_thread_present;
         depth_ff    <= req_thread_lock_depth;
         now_ff      <= req_time_ms;
      end
      if (cmd.search && hit) begin
         entry_ff <= rd_data_ff;
         slot_ff  <= {bucket, chk_way_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         way_ff       <= '0;
         chk_way_ff   <= '0;
         chk_valid_ff <= 1'b0;
         over_ff      <= 1'b1;
         clr_addr_ff  <= '0;
      end else begin
         if (cmd.capture) begin
            way_ff       <= '0;
            chk_valid_ff <= 1'b0;
            over_ff      <= 1'b1;
         end else begin
            chk_valid_ff <= cmd.search;
            if (cmd.search) begin
               way_ff     <= way_ff + 1'b1;
               chk_way_ff <= way_ff;
               if (hit)
                  over_ff <= 1'b0;
            end
         end
         if (cmd.clear_start)
            clr_addr_ff <= '0;
         else if (cmd.clear_step)
            clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // update of the chosen entry
   always_comb begin
      if (over_ff) begin
         base_entry.owner   = 32'd0;
         base_entry.caller  = 32'd0;
         base_entry.success = ovf_success_ff;
         base_entry.fail    = ovf_fail_ff;
         base_entry.masked  = ovf_masked_ff;
         base_entry.depth   = ovf_depth_ff;
         base_entry.mark    = ovf_mark_ff;
      end else begin
         base_entry = entry_ff;
         // claim an empty slot
         if (entry_ff.owner == 32'd0) begin
            base_entry.owner  = addr_ff;
            base_entry.caller = caller_ff;
         end
      end
      new_entry = base_entry;
      unique case (action_ff)
         ACT_LOCK: begin
            if (thread_ff)
               new_entry.depth = depth_ff;
            if (masked_ff)
               new_entry.masked = base_entry.masked + 32'd1;
            if (acquired_ff)
               new_entry.success = base_entry.success + 32'd1;
            else
               new_entry.fail = base_entry.fail + 32'd1;
            new_entry.mark = now_ff - base_entry.mark;
         end
         ACT_TRY: begin
            if (masked_ff)
               new_entry.masked = base_entry.masked + 32'd1;
            if (acquired_ff) begin
               new_entry.success = base_entry.success + 32'd1;
               new_entry.mark    = now_ff - base_entry.mark;
               if (thread_ff)
                  new_entry.depth = depth_ff;
            end else begin
               new_entry.fail = base_entry.fail + 32'd1;
            end
         end
         default: begin
            new_entry.mark = now_ff - base_entry.mark;
         end
      endcase
   end

   always_comb begin
      mem_we  = cmd.clear_step || (cmd.update && !over_ff);
      wr_addr = cmd.clear_step ? clr_addr_ff : slot_ff;
      wr_data = cmd.clear_step ? '0 : new_entry;
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         ovf_success_ff <= '0;
         ovf_fail_ff    <= '0;
         ovf_masked_ff  <= '0;
         ovf_depth_ff   <= '0;
         ovf_mark_ff    <= '0;
      end else if (cmd.update && over_ff) begin
         ovf_success_ff <= new_entry.success;
         ovf_fail_ff    <= new_entry.fail;
         ovf_masked_ff  <= new_entry.masked;
         ovf_depth_ff   <= new_entry.depth;
         ovf_mark_ff    <= new_entry.mark;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update || cmd.rsp_zero) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_zero) begin
         rsp_over_ff  <= 1'b0;
         rsp_index_ff <= '0;
         rsp_entry_ff <= '0;
      end else if (cmd.update) begin
         rsp_over_ff  <= over_ff;
         rsp_index_ff <= over_ff ? 15'd0 : 15'(slot_ff);
         rsp_entry_ff <= new_entry;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_overflowed    = rsp_over_ff;
   assign rsp_slot_index    = rsp_index_ff;
   assign rsp_success_count = rsp_entry_ff.success;
   assign rsp_fail_count    = rsp_entry_ff.fail;
   assign rsp_masked_count  = rsp_entry_ff.masked;
   assign rsp_depth_record  = rsp_entry_ff.depth;
   assign rsp_time_mark     = rsp_entry_ff.mark;
   assign rsp_caller_record = rsp_entry_ff.caller;

endmodule

// ----- sv/lcmt_ctrl.sv -----
// Controller state machine: clearing pass, bucket search, update, result hand-off.
// Depends on lcmt_pkg and lock_contention_monitor_table_assert.svh.
`include "lock_contention_monitor_table_assert.svh"
module lcmt_ctrl import lcmt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      clr_item_ff, clr_item_in;
   logic      accept;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_item_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_item_ff <= clr_item_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_item_in = clr_item_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last)
               state_in = clr_item_ff ? ST_CLR_RSP : ST_IDLE;
         end
         ST_CLR_RSP: begin
            if (!status.rsp_busy) begin
               state_in    = ST_IDLE;
               clr_item_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               priority if (status.req_clear) begin
                  state_in    = ST_CLEAR;
                  clr_item_in = 1'b1;
               end else if (status.req_zero) begin
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (status.found || status.full)
               state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!status.rsp_busy)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      cmd             = '0;
      cmd.capture     = accept;
      cmd.clear_start = accept && status.req_clear;
      cmd.clear_step  = (state_ff == ST_CLEAR);
      // hold the search until a slot matches or the bucket runs out
      cmd.search      = (state_ff == ST_SEARCH) && !status.found && !status.full ||
                        (state_ff == ST_SEARCH) && status.found;
      cmd.update      = (state_ff == ST_UPDATE) && !status.rsp_busy;
      cmd.rsp_zero    = (state_ff == ST_CLR_RSP) && !status.rsp_busy;
   end

   `LCMT_NEVER(a_no_overwrite, (cmd.update || cmd.rsp_zero) && status.rsp_busy)
   `LCMT_NEVER(a_clear_excl, cmd.clear_step && (cmd.search || cmd.update))
   `LCMT_ASSERT(a_found_update, (state_ff == ST_SEARCH && status.found) |=> state_ff == ST_UPDATE)

endmodule

// ----- sv/lock_contention_monitor_table.sv -----
// Lock contention monitor table, top level: controller plus datapath.
// Depends on lcmt_pkg, lcmt_ctrl and lcmt_datapath.
//
//   port group  direction  handshake            payload
//   req_*       in         req_valid/req_ready  event fields
//   rsp_*       out        rsp_valid/rsp_ready  updated entry fields
//
// An event with a nonzero lock address first searches its bucket, reading
// one slot per cycle from the slot memory, then updates the chosen entry.
// A clear event and reset each run a clearing pass over all SLOT_TOTAL slots
// (32768), one slot per cycle, with req_ready low.
// A pending result stalls the update and clear-result steps; req_ready stays low then.
module lock_contention_monitor_table import lcmt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_lock_address,
   input  logic [31:0] req_caller_address,
   input  logic        req_acquired_at_once,
   input  logic        req_interrupts_masked,
   input  logic        req_thread_present,
   input  logic [31:0] req_thread_lock_depth,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_overflowed,
   output logic [14:0] rsp_slot_index,
   output logic [31:0] rsp_success_count,
   output logic [31:0] rsp_fail_count,
   output logic [31:0] rsp_masked_count,
   output logic [31:0] rsp_depth_record,
   output logic [31:0] rsp_time_mark,
   output logic [31:0] rsp_caller_record
);

   dp_cmd_type    cmd;
   dp_status_type status;

   lcmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcmt_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_action            (req_action),
      .req_lock_address      (req_lock_address),
      .req_caller_address    (req_caller_address),
      .req_acquired_at_once  (req_acquired_at_once),
      .req_interrupts_masked (req_interrupts_masked),
      .req_thread_present    (req_thread_present),
      .req_thread_lock_depth (req_thread_lock_depth),
      .req_time_ms           (req_time_ms),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_overflowed        (rsp_overflowed),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_success_count     (rsp_success_count),
      .rsp_fail_count        (rsp_fail_count),
      .rsp_masked_count      (rsp_masked_count),
      .rsp_depth_record      (rsp_depth_record),
      .rsp_time_mark         (rsp_time_mark),
      .rsp_caller_record     (rsp_caller_record)
   );

endmodule
